// ----- sv/mmcp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the motor command packer: field widths, the default fixed-point
// format and the configuration register indexes. No dependencies.
package mmcp_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int TARGET_W    = 32;
   localparam int KP_W        = 25;
   localparam int KD_W        = 19;
   localparam int TFF_W       = 22;
   localparam int CSR_DATA_W  = 25;
   localparam int CSR_INDEX_W = 2;
   localparam int FRAME_W     = 64;

   localparam int POS_CODE_W   = 16;
   localparam int SMALL_CODE_W = 12;

   localparam logic [KP_W-1:0]  KP_RESET  = KP_W'(1966080);
   localparam logic [KD_W-1:0]  KD_RESET  = KD_W'(65536);
   localparam logic [TFF_W-1:0] TFF_RESET = '0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP  = 2'd0,
      CSR_KD  = 2'd1,
      CSR_TFF = 2'd2
   } csr_index_type;

endpackage

// ----- sv/mit_motor_command_packer.sv -----
`timescale 1ns / 1ps
// Top level of the motor command packer: clamps and quantizes targets and gains
// into the 8-byte command frame. Depends on mmcp_pkg.
//
// Usage:
//   Command channel: a beat is taken at a clock edge with start high and busy
//   low. busy is always low, so one beat can be taken every cycle.
//   Result channel: rsp_valid is high for one cycle with rsp_frame_payload,
//   rsp_pos_clamped and rsp_vel_clamped; the receiver cannot stall it.
//   A beat passes through the input register, then the result register;
//   throughput is 1 beat per cycle. Each code is one constant multiply of the
//   clamped offset by a scaled reciprocal of its span, then a fixed bit select.
//   Gains and feed-forward torque come from the csr_ write port (index 0 kp,
//   index 1 kd, index 2 torque, other indexes ignored); the user must write
//   them only while no beat is in flight, as the block does not enforce it.
//   Reset clears the pipeline valid bits and loads kp 30.0, kd 1.0 and
//   torque 0; it is usable the cycle after reset drops.
module mit_motor_command_packer #(
   parameter int FRAC_BITS = mmcp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [mmcp_pkg::TARGET_W-1:0] req_pos_target,
   input  logic signed [mmcp_pkg::TARGET_W-1:0] req_vel_target,
   input  logic                                 csr_we,
   input  logic [mmcp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mmcp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 rsp_valid,
   output logic [mmcp_pkg::FRAME_W-1:0]         rsp_frame_payload,
   output logic                                 rsp_pos_clamped,
   output logic                                 rsp_vel_clamped
);
   import mmcp_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int CW = (F + 11 > TARGET_W + 1) ? F + 11 : TARGET_W + 1;

   // span = c * 2^F; code = floor(d * M >> (2F + K)) with 2^K > c^2
   localparam int K_POS = 10;
   localparam int K_VEL = 13;
   localparam int K_KP  = 18;
   localparam int K_KD  = 5;
   localparam int K_TQ  = 11;

   localparam int DW_POS = F + 5;
   localparam int DW_VEL = F + 7;
   localparam int DW_KP  = F + 9;
   localparam int DW_KD  = F + 3;
   localparam int DW_TQ  = F + 6;

   localparam int MW_POS = F + 26;
   localparam int MW_VEL = F + 25;
   localparam int MW_KP  = F + 30;
   localparam int MW_KD  = F + 17;
   localparam int MW_TQ  = F + 23;

   localparam int PW_POS = DW_POS + MW_POS;
   localparam int PW_VEL = DW_VEL + MW_VEL;
   localparam int PW_KP  = DW_KP + MW_KP;
   localparam int PW_KD  = DW_KD + MW_KD;
   localparam int PW_TQ  = DW_TQ + MW_TQ;

   localparam logic [63:0] M64_POS = ((64'd65535 << (F + K_POS)) + 64'd24) / 64'd25;
   localparam logic [63:0] M64_VEL = ((64'd4095 << (F + K_VEL)) + 64'd89) / 64'd90;
   localparam logic [63:0] M64_KP  = ((64'd4095 << (F + K_KP)) + 64'd499) / 64'd500;
   localparam logic [63:0] M64_KD  = ((64'd4095 << (F + K_KD)) + 64'd4) / 64'd5;
   localparam logic [63:0] M64_TQ  = ((64'd4095 << (F + K_TQ)) + 64'd35) / 64'd36;

   localparam logic [MW_POS-1:0] M_POS = M64_POS[MW_POS-1:0];
   localparam logic [MW_VEL-1:0] M_VEL = M64_VEL[MW_VEL-1:0];
   localparam logic [MW_KP-1:0]  M_KP  = M64_KP[MW_KP-1:0];
   localparam logic [MW_KD-1:0]  M_KD  = M64_KD[MW_KD-1:0];
   localparam logic [MW_TQ-1:0]  M_TQ  = M64_TQ[MW_TQ-1:0];

   localparam logic signed [CW-1:0] POS_HI = CW'(64'd25 << (F - 1));
   localparam logic signed [CW-1:0] VEL_HI = CW'(64'd45 << F);
   localparam logic signed [CW-1:0] KP_HI  = CW'(64'd500 << F);
   localparam logic signed [CW-1:0] KD_HI  = CW'(64'd5 << F);
   localparam logic signed [CW-1:0] TQ_HI  = CW'(64'd18 << F);

   logic [KP_W-1:0]  kp_ff, kp_in;
   logic [KD_W-1:0]  kd_ff, kd_in;
   logic [TFF_W-1:0] tff_ff, tff_in;

   logic                       req_valid_ff;
   logic signed [TARGET_W-1:0] pos_ff, vel_ff;

   logic                       rsp_valid_ff;
   logic [FRAME_W-1:0]         frame_ff, frame_in;
   logic                       pos_clamped_ff, pos_clamped_in;
   logic                       vel_clamped_ff, vel_clamped_in;

   logic signed [CW-1:0] pos_x, vel_x, kp_x, kd_x, tq_x;
   logic signed [CW-1:0] pos_sat, vel_sat, kp_sat, kd_sat, tq_sat;
   logic signed [CW-1:0] pos_ofs, vel_ofs, tq_ofs;
   logic [PW_POS-1:0]    pos_prod;
   logic [PW_VEL-1:0]    vel_prod;
   logic [PW_KP-1:0]     kp_prod;
   logic [PW_KD-1:0]     kd_prod;
   logic [PW_TQ-1:0]     tq_prod;
   logic [DW_POS-1:0]    pos_d;
   logic [DW_VEL-1:0]    vel_d;
   logic [DW_KP-1:0]     kp_d;
   logic [DW_KD-1:0]     kd_d;
   logic [DW_TQ-1:0]     tq_d;

   assign busy = 1'b0;

   always_comb begin
      kp_in  = kp_ff;
      kd_in  = kd_ff;
      tff_in = tff_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KP:  kp_in  = csr_wdata[KP_W-1:0];
            CSR_KD:  kd_in  = csr_wdata[KD_W-1:0];
            CSR_TFF: tff_in = csr_wdata[TFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= KP_RESET;
         kd_ff  <= KD_RESET;
         tff_ff <= TFF_RESET;
      end else begin
         kp_ff  <= kp_in;
         kd_ff  <= kd_in;
         tff_ff <= tff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         pos_ff <= req_pos_target;
         vel_ff <= req_vel_target;
      end
   end

   // clamp to span, offset from the low bound
   always_comb begin
      pos_x = {{(CW - TARGET_W){pos_ff[TARGET_W-1]}}, pos_ff};
      vel_x = {{(CW - TARGET_W){vel_ff[TARGET_W-1]}}, vel_ff};
      kp_x  = {{(CW - KP_W){1'b0}}, kp_ff};
      kd_x  = {{(CW - KD_W){1'b0}}, kd_ff};
      tq_x  = {{(CW - TFF_W){tff_ff[TFF_W-1]}}, tff_ff};

      pos_clamped_in = (pos_x < -POS_HI) || (pos_x > POS_HI);
      vel_clamped_in = (vel_x < -VEL_HI) || (vel_x > VEL_HI);

      priority if (pos_x < -POS_HI) pos_sat = -POS_HI;
      else if (pos_x > POS_HI)      pos_sat = POS_HI;
      else                          pos_sat = pos_x;

      priority if (vel_x < -VEL_HI) vel_sat = -VEL_HI;
      else if (vel_x > VEL_HI)      vel_sat = VEL_HI;
      else                          vel_sat = vel_x;

      priority if (tq_x < -TQ_HI) tq_sat = -TQ_HI;
      else if (tq_x > TQ_HI)      tq_sat = TQ_HI;
      else                        tq_sat = tq_x;

      kp_sat = (kp_x > KP_HI) ? KP_HI : kp_x;
      kd_sat = (kd_x > KD_HI) ? KD_HI : kd_x;

      pos_ofs = pos_sat + POS_HI;
      vel_ofs = vel_sat + VEL_HI;
      tq_ofs  = tq_sat + TQ_HI;

      pos_d = pos_ofs[DW_POS-1:0];
      vel_d = vel_ofs[DW_VEL-1:0];
      kp_d  = kp_sat[DW_KP-1:0];
      kd_d  = kd_sat[DW_KD-1:0];
      tq_d  = tq_ofs[DW_TQ-1:0];

      pos_prod = {{(PW_POS - DW_POS){1'b0}}, pos_d} * {{(PW_POS - MW_POS){1'b0}}, M_POS};
      vel_prod = {{(PW_VEL - DW_VEL){1'b0}}, vel_d} * {{(PW_VEL - MW_VEL){1'b0}}, M_VEL};
      kp_prod  = {{(PW_KP - DW_KP){1'b0}}, kp_d} * {{(PW_KP - MW_KP){1'b0}}, M_KP};
      kd_prod  = {{(PW_KD - DW_KD){1'b0}}, kd_d} * {{(PW_KD - MW_KD){1'b0}}, M_KD};
      tq_prod  = {{(PW_TQ - DW_TQ){1'b0}}, tq_d} * {{(PW_TQ - MW_TQ){1'b0}}, M_TQ};

      frame_in = {pos_prod[2*F + K_POS +: POS_CODE_W],
                  vel_prod[2*F + K_VEL +: SMALL_CODE_W],
                  kp_prod[2*F + K_KP +: SMALL_CODE_W],
                  kd_prod[2*F + K_KD +: SMALL_CODE_W],
                  tq_prod[2*F + K_TQ +: SMALL_CODE_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         frame_ff       <= frame_in;
         pos_clamped_ff <= pos_clamped_in;
         vel_clamped_ff <= vel_clamped_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_payload = frame_ff;
   assign rsp_pos_clamped   = pos_clamped_ff;
   assign rsp_vel_clamped   = vel_clamped_ff;

endmodule
